@@ rtl/ntrk_pkg.sv @@
package ntrk_pkg;

  localparam int ADDR_W   = 14;
  localparam int SEQ_W    = 8;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_FULL    = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_OWN_ADDRESS       = 1'b0,
    REG_BROADCAST_ADDRESS = 1'b1
  } cfg_reg_t;

  // What an item does to the table entry of its key address.
  typedef enum logic [2:0] {
    OP_LEARN = 3'b001,
    OP_SEND  = 3'b010,
    OP_RECV  = 3'b100
  } op_t;

  // One neighbour table entry as stored in memory.
  typedef struct packed {
    addr_t addr;
    seq_t  sent;
    seq_t  recv;
  } entry_t;

  // One result item.
  typedef struct packed {
    status_t status;
    seq_t    seq_out;
    logic    refresh;
  } result_t;

endpackage

@@ rtl/ntrk_table.sv @@
module ntrk_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  ntrk_pkg::entry_t  wr_entry,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output ntrk_pkg::entry_t  rd_entry
);
  import ntrk_pkg::*;

  entry_t mem [DEPTH];

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ntrk_ctrl.sv @@
module ntrk_ctrl #(
  parameter int MAX_NEIGHBOURS = 16,
  parameter int IDX_W          = 4,
  parameter int CNT_W          = 5
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration writes
  input  logic                cfg_wr_en,
  input  ntrk_pkg::cfg_reg_t  cfg_index,
  input  ntrk_pkg::addr_t     cfg_data,
  // Incoming header
  input  logic                in_valid,
  output logic                in_ready,
  input  ntrk_pkg::addr_t     in_dest,
  input  ntrk_pkg::addr_t     in_source,
  input  ntrk_pkg::seq_t      in_seq,
  // Result toward the output register
  output logic                res_valid,
  input  logic                res_ready,
  output ntrk_pkg::result_t   res,
  // Table memory
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output ntrk_pkg::entry_t    wr_entry,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  input  ntrk_pkg::entry_t    rd_entry
);
  import ntrk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_UPDATE = 5'b00100,
    S_DROP   = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state;
  addr_t            own_address;
  addr_t            broadcast_address;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] last_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] hit_idx;
  entry_t           hit_entry;
  logic             hit;
  op_t              op;
  addr_t            key;
  seq_t             seq;
  logic             issue;
  logic             match;
  logic             count_inc;
  logic             go_drop;
  result_t          upd_res;
  seq_t             new_sent;
  seq_t             new_recv;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && res_ready;
  assign last_idx  = count - 1'b1;
  assign issue     = (state == S_SCAN) && (scan_idx < count);
  assign match     = pend && (rd_entry.addr == key);
  assign new_sent  = SEQ_W'(hit_entry.sent + 1'b1);
  assign new_recv  = SEQ_W'(hit_entry.recv + 1'b1);

  // Memory port control and the read-modify-write decision.
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = hit_idx;
    wr_entry  = hit_entry;
    rd_en     = 1'b0;
    rd_addr   = scan_idx[IDX_W-1:0];
    count_inc = 1'b0;
    go_drop   = 1'b0;
    upd_res   = '{status: STATUS_OK, seq_out: '0, refresh: 1'b0};
    case (state)
      S_SCAN: begin
        rd_en = issue;
      end
      S_UPDATE: begin
        if (hit) begin
          case (op)
            OP_SEND: begin
              wr_en          = 1'b1;
              wr_entry.sent  = new_sent;
              upd_res.seq_out = new_sent;
            end
            OP_RECV: begin
              upd_res.refresh = 1'b1;
              if (new_recv == seq) begin
                wr_en         = 1'b1;
                wr_entry.recv = new_recv;
              end else begin
                // Mismatch: fetch the last entry to move into this slot.
                upd_res.status = STATUS_INVALID;
                go_drop        = 1'b1;
                rd_en          = 1'b1;
                rd_addr        = last_idx[IDX_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end else if (key == own_address) begin
          // Own address is never learned.
          if (op != OP_LEARN) begin
            upd_res.status = STATUS_INVALID;
          end
        end else if (count == CNT_W'(MAX_NEIGHBOURS)) begin
          upd_res.status = STATUS_FULL;
        end else begin
          // New entry in the first free slot.
          wr_addr  = count[IDX_W-1:0];
          wr_entry = '{addr: key, sent: '0, recv: '0};
          case (op)
            OP_SEND: begin
              wr_en           = 1'b1;
              count_inc       = 1'b1;
              wr_entry.sent   = SEQ_W'(1);
              upd_res.seq_out = SEQ_W'(1);
            end
            OP_RECV: begin
              upd_res.refresh = 1'b1;
              if (seq == SEQ_W'(1)) begin
                wr_en         = 1'b1;
                count_inc     = 1'b1;
                wr_entry.recv = SEQ_W'(1);
              end else begin
                // The new entry would be dropped at once.
                upd_res.status = STATUS_INVALID;
              end
            end
            default: begin
              wr_en     = 1'b1;
              count_inc = 1'b1;
            end
          endcase
        end
      end
      S_DROP: begin
        wr_en    = 1'b1;
        wr_addr  = hit_idx;
        wr_entry = rd_entry;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      count             <= '0;
      pend              <= 1'b0;
      own_address       <= '0;
      broadcast_address <= '1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_OWN_ADDRESS:       own_address       <= cfg_data;
          REG_BROADCAST_ADDRESS: broadcast_address <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            seq      <= in_seq;
            scan_idx <= '0;
            pend     <= 1'b0;
            if (in_dest == broadcast_address) begin
              op    <= OP_LEARN;
              key   <= in_source;
              res   <= '{status: STATUS_OK, seq_out: '0, refresh: 1'b0};
              state <= S_SCAN;
            end else if (in_source == own_address) begin
              op    <= OP_SEND;
              key   <= in_dest;
              res   <= '{status: STATUS_OK, seq_out: '0, refresh: 1'b0};
              state <= (in_dest == '0) ? S_DONE : S_SCAN;
            end else if (in_dest == own_address) begin
              op    <= OP_RECV;
              key   <= in_source;
              res   <= '{status: STATUS_OK, seq_out: '0, refresh: 1'b0};
              if (in_source == broadcast_address || in_source == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else begin
              // Header unrelated to this node.
              res   <= '{status: STATUS_INVALID, seq_out: '0, refresh: 1'b0};
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          pend     <= issue;
          pend_idx <= scan_idx[IDX_W-1:0];
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (match) begin
            hit       <= 1'b1;
            hit_idx   <= pend_idx;
            hit_entry <= rd_entry;
            state     <= S_UPDATE;
          end else if (!issue && !pend) begin
            hit   <= 1'b0;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          res <= upd_res;
          if (count_inc) begin
            count <= count + 1'b1;
          end
          state <= go_drop ? S_DROP : S_DONE;
        end
        S_DROP: begin
          count <= last_idx;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/neighbour_sequence_tracker.sv @@
// Neighbour sequence tracker. Each input item is one link header; each gives
// exactly one result item. The neighbour table lives in a single-port-read,
// single-port-write memory and is searched one entry per cycle, so an item
// whose address is not in the table reads every entry, and a search stops at
// the first hit; a sequence mismatch that removes an entry adds a drop state
// that moves the last entry into the removed slot. Headers that need no table
// access skip the scan and go straight to the done state.
// A new header is taken while the previous result still waits in the output
// register. No clearing pass is needed after reset.
module neighbour_sequence_tracker #(
  parameter int MAX_NEIGHBOURS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port
  input  logic               cfg_wr_en,
  input  ntrk_pkg::cfg_reg_t cfg_index,
  input  logic [13:0]        cfg_data,
  // Header input
  input  logic               s_tvalid,
  output logic               s_tready,
  // [13:0] dest_address, [27:14] source_address, [35:28] carried_sequence
  input  logic [39:0]        s_tdata,
  // Result output
  output logic               m_tvalid,
  input  logic               m_tready,
  // [1:0] status, [9:2] sequence_out, [10] refresh_route
  output logic [15:0]        m_tdata
);
  import ntrk_pkg::*;

  localparam int IDX_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);

  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out_res;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;

  ntrk_ctrl #(
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
    .IDX_W          (IDX_W),
    .CNT_W          (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_dest   (s_tdata[13:0]),
    .in_source (s_tdata[27:14]),
    .in_seq    (s_tdata[35:28]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry)
  );

  ntrk_table #(
    .DEPTH (MAX_NEIGHBOURS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // Output register: holds a finished item until the sink takes it.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b0, out_res.refresh, out_res.seq_out, out_res.status};

endmodule

@@ tb/sv/tb_neighbour_sequence_tracker.sv @@
`timescale 1ns / 100ps

module tb_neighbour_sequence_tracker;
  import ntrk_pkg::*;

  localparam int MAX_NEIGHBOURS = 16;
  localparam int IDLE_PERCENT = 13;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PEER_POOL_SIZE = 20;
  localparam int DRAIN_CYCLES = MAX_NEIGHBOURS + 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  cfg_reg_t    cfg_index = REG_OWN_ADDRESS;
  logic [13:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [13:0] dest_address, [27:14] source_address, [35:28] carried_sequence
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] status, [9:2] sequence_out, [10] refresh_route
  logic [15:0] m_tdata;

  // Shadow copy of the address registers and the neighbor table.
  addr_t own_addr = '0;
  addr_t bcast_addr = 14'h3FFF;
  addr_t peer_addr[MAX_NEIGHBOURS];
  seq_t  peer_sent[MAX_NEIGHBOURS];
  seq_t  peer_recv[MAX_NEIGHBOURS];
  int    peer_count = 0;

  // Expected results, oldest first.
  result_t pending_results[$];

  addr_t peer_pool[PEER_POOL_SIZE];
  addr_t next_fresh = 14'h0100;
  bit    random_idle = 1'b1;
  int    hold_requests = 0;
  int    holds_taken = 0;
  int    hold_left = 0;
  int    items_sent = 0;
  int    results_seen = 0;
  int    mismatches = 0;
  int    settings_used = 0;
  int    status_hits[3] = '{0, 0, 0};

  neighbour_sequence_tracker #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Index of an address in the table, or the entry count when it is absent.
  function automatic int find_peer(addr_t a);
    for (int i = 0; i < peer_count; i++) begin
      if (peer_addr[i] == a) return i;
    end
    return peer_count;
  endfunction

  // Adds an unknown address; fails only when a slot is needed and none is free.
  function automatic bit learn_peer(addr_t a);
    if (a == own_addr || find_peer(a) < peer_count) return 1'b1;
    if (peer_count >= MAX_NEIGHBOURS) return 1'b0;
    peer_addr[peer_count] = a;
    peer_sent[peer_count] = '0;
    peer_recv[peer_count] = '0;
    peer_count++;
    return 1'b1;
  endfunction

  // Applies one header to the shadow table and returns the result it causes.
  function automatic result_t track_header(addr_t dst, addr_t src, seq_t seq);
    result_t res;
    int idx;
    int last;
    res.status = STATUS_INVALID;
    res.seq_out = '0;
    res.refresh = 1'b0;
    if (dst == bcast_addr) begin
      res.status = learn_peer(src) ? STATUS_OK : STATUS_FULL;
    end else if (src == own_addr) begin
      if (dst == '0) begin
        res.status = STATUS_OK;
      end else if (!learn_peer(dst)) begin
        res.status = STATUS_FULL;
      end else begin
        idx = find_peer(dst);
        if (idx < peer_count) begin
          peer_sent[idx] = peer_sent[idx] + 8'd1;
          res.seq_out = peer_sent[idx];
          res.status = STATUS_OK;
        end
      end
    end else if (dst == own_addr) begin
      if (src == bcast_addr || src == '0) begin
        res.status = STATUS_OK;
      end else if (!learn_peer(src)) begin
        res.status = STATUS_FULL;
      end else begin
        idx = find_peer(src);
        if (idx < peer_count) begin
          peer_recv[idx] = peer_recv[idx] + 8'd1;
          res.refresh = 1'b1;
          if (peer_recv[idx] == seq) begin
            res.status = STATUS_OK;
          end else begin
            // Out-of-order sequence: the last entry takes over the slot.
            last = peer_count - 1;
            peer_addr[idx] = peer_addr[last];
            peer_sent[idx] = peer_sent[last];
            peer_recv[idx] = peer_recv[last];
            peer_count = last;
          end
        end
      end
    end
    return res;
  endfunction

  // Returns an address that is neither in the table nor special.
  function automatic addr_t fresh_address();
    do begin
      next_fresh = next_fresh + 14'd1;
    end while (next_fresh == '0 || next_fresh == own_addr || next_fresh == bcast_addr ||
               find_peer(next_fresh) < peer_count);
    return next_fresh;
  endfunction

  // Draws a set of neighbor addresses, a few more than the table holds.
  function automatic void build_peer_pool();
    for (int i = 0; i < PEER_POOL_SIZE; i++) begin
      do begin
        peer_pool[i] = addr_t'($urandom_range(1, 16382));
      end while (peer_pool[i] == own_addr || peer_pool[i] == bcast_addr);
    end
  endfunction

  // Offers one header and records its expected result once it is taken.
  task automatic send_header(addr_t dst, addr_t src, seq_t seq);
    if (random_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid = 1'b0;
      s_tdata = {8'($urandom), 32'($urandom)};
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
    s_tdata = {4'b0000, seq, src, dst};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(track_header(dst, src, seq));
    items_sent++;
    @(negedge clk);
  endtask

  // Stops offering items and waits until every expected result has come.
  task automatic wait_for_results();
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(cfg_reg_t idx, addr_t value);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == REG_OWN_ADDRESS) own_addr = value;
    else bcast_addr = value;
  endtask

  // Mostly well-formed link traffic among the pool, with some noise.
  task automatic run_traffic(int count);
    addr_t dst;
    addr_t src;
    seq_t seq;
    int pick;
    int idx;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      src = peer_pool[$urandom_range(PEER_POOL_SIZE - 1)];
      dst = peer_pool[$urandom_range(PEER_POOL_SIZE - 1)];
      seq = seq_t'($urandom);
      if (pick < 25) begin
        dst = bcast_addr;
      end else if (pick < 55) begin
        src = own_addr;
        if ($urandom_range(99) < 5) dst = '0;
        else if ($urandom_range(99) < 3) dst = own_addr;
      end else if (pick < 85) begin
        dst = own_addr;
        if ($urandom_range(99) < 4) src = bcast_addr;
        else if ($urandom_range(99) < 4) src = '0;
        idx = find_peer(src);
        // A correct sequence keeps the entry; a few wrong ones remove it.
        if ($urandom_range(99) < 90) seq = (idx < peer_count) ? peer_recv[idx] + 8'd1 : 8'd1;
      end else begin
        dst = addr_t'($urandom);
        src = addr_t'($urandom);
      end
      send_header(dst, src, seq);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_requests != holds_taken) begin
      holds_taken = hold_requests;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = !(random_idle && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    status_t got_status;
    seq_t got_seq;
    logic got_refresh;
    if (!rst && m_tvalid && m_tready) begin
      got_status = status_t'(m_tdata[1:0]);
      got_seq = m_tdata[9:2];
      got_refresh = m_tdata[10];
      results_seen++;
      if (m_tdata[1:0] < 2'd3) status_hits[m_tdata[1:0]]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: result with none expected: status %0d seq %0d refresh %0d",
                   $realtime, got_status, got_seq, got_refresh);
      end else begin
        want = pending_results.pop_front();
        if (got_status != want.status || got_seq != want.seq_out ||
            got_refresh != want.refresh) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: expected status %0d seq %0d refresh %0d, got %0d %0d %0d",
                     $realtime, want.status, want.seq_out, want.refresh,
                     got_status, got_seq, got_refresh);
        end
      end
    end
  end

  // Every header class once, with field extremes and both removal paths.
  task automatic test_header_classes();
    addr_t a;
    addr_t b;
    a = 14'h1555;
    b = 14'h2AAA;
    write_register(REG_OWN_ADDRESS, a);
    write_register(REG_BROADCAST_ADDRESS, b);
    settings_used++;
    send_header(b, 14'h0123, 8'd0);
    send_header(b, a, 8'd7);
    send_header(14'h0000, a, 8'd0);
    send_header(a, a, 8'd0);
    send_header(14'h0123, a, 8'd0);
    send_header(14'h0123, a, 8'd0);
    send_header(a, 14'h0123, 8'd1);
    send_header(a, b, 8'd9);
    send_header(a, 14'h0000, 8'd9);
    send_header(a, 14'h3FFE, 8'd0);
    send_header(14'h3FFF, 14'h0000, 8'd255);
    send_header(a, 14'h0123, 8'd255);
    send_header(14'h3FFF, a, 8'd0);
  endtask

  // Fill the table, then show refusals, a removal and a re-learn.
  task automatic test_table_full();
    addr_t extra;
    while (peer_count < MAX_NEIGHBOURS) send_header(bcast_addr, fresh_address(), 8'd0);
    extra = fresh_address();
    send_header(bcast_addr, extra, 8'd0);
    send_header(extra, own_addr, 8'd0);
    send_header(own_addr, extra, 8'd1);
    send_header(peer_addr[3], own_addr, 8'd0);
    send_header(own_addr, peer_addr[5], 8'd200);
    send_header(bcast_addr, extra, 8'd0);
  endtask

  // Drive one neighbor's counters all the way around, with no idling.
  task automatic test_counter_wrap();
    addr_t peer;
    random_idle = 1'b0;
    peer = peer_addr[0];
    for (int n = 0; n < 256; n++) begin
      send_header(peer, own_addr, 8'd0);
      send_header(own_addr, peer, peer_recv[find_peer(peer)] + 8'd1);
    end
    random_idle = 1'b1;
  endtask

  // The receiver holds off while headers keep coming, so the input stalls.
  task automatic test_output_stall();
    build_peer_pool();
    hold_requests++;
    run_traffic(12);
  endtask

  // Traffic under several address settings, extremes first.
  task automatic test_address_settings();
    addr_t own_list[5];
    addr_t bcast_list[5];
    own_list = '{14'h0000, 14'h3FFF, addr_t'($urandom), addr_t'($urandom), 14'h0ABC};
    bcast_list = '{14'h3FFF, 14'h0000, addr_t'($urandom), addr_t'($urandom), 14'h0ABC};
    for (int k = 0; k < 5; k++) begin
      write_register(REG_OWN_ADDRESS, own_list[k]);
      write_register(REG_BROADCAST_ADDRESS, bcast_list[k]);
      settings_used++;
      build_peer_pool();
      run_traffic(120);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_header_classes();
    test_table_full();
    test_counter_wrap();
    test_output_stall();
    test_address_settings();
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d headers under %0d address settings.",
             results_seen, items_sent, settings_used);
    $display("Status ok %0d, invalid %0d, table full %0d; counter wrap and a %0d-cycle stall.",
             status_hits[0], status_hits[1], status_hits[2], LONG_HOLD_CYCLES);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ntrk_pkg.sv
rtl/ntrk_table.sv
rtl/ntrk_ctrl.sv
rtl/neighbour_sequence_tracker.sv
tb/sv/tb_neighbour_sequence_tracker.sv
